>>> rtl/msce_pkg.sv
// Shared constants, codes and types for the marching-squares cell edge block.
package msce_pkg;

  localparam int IDX_W     = 10;
  localparam int SMP_W     = 16;
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 27;
  localparam int TOL_W     = 15;

  // Level-shifted and nudged sample, and its edge difference.
  localparam int NUM_W = SMP_W + 2;
  localparam int DEN_W = NUM_W + 1;
  localparam int REM_W = DEN_W + 1;
  localparam int PRD_W = 2 * NUM_W;
  localparam int DET_W = PRD_W + 1;

  // Quotient bits carry weights 2^FRAC_BITS down to 2^0.
  localparam int QUO_W    = FRAC_BITS + 1;
  localparam int EDGE_LAT = QUO_W + 2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_ISO_LEVEL       = 2'd0;
  localparam logic [1:0] REG_NUDGE_ENABLE    = 2'd1;
  localparam logic [1:0] REG_NUDGE_TOLERANCE = 2'd2;
  localparam logic [1:0] REG_REVERSE_WINDING = 2'd3;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_HALF = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;

  localparam logic signed [1:0] SG_POS  = 2'sb01;
  localparam logic signed [1:0] SG_ZERO = 2'sb00;
  localparam logic signed [1:0] SG_NEG  = 2'sb11;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic [1:0]       mode;
    logic             ovf;
    logic [IDX_W-1:0] ci;
    logic [IDX_W-1:0] cj;
    logic [1:0]       ca;
    logic [1:0]       cb;
  } msce_div_t;

endpackage

>>> rtl/marching_squares_cell_edges.sv
// Top level: marching-squares cell to contour segments.
// Use: present one grid cell (cell_first, cell_second and four corner samples)
// with start; the request is taken at a clock edge where start is high and
// busy is low. Each cell yields 0 to 4 segments, each shown on the result
// ports for one cycle with strobe high; last_segment marks the final one of
// the cell. A cell with no segment shows nothing.
// The first segment of a cell goes through stages 1 to 3, the issuer and the
// edge units' division pipeline to the ports, later if cells queue up.
// Throughput: the segment issuer sends one segment per cycle into two
// pipelined dividers, and the front stages take a new cell every cycle while
// the issuer keeps up.
// Configuration goes through the APB port (pready always high); write it only
// while no cell is in flight. Reset (synchronous, rst high) empties all
// stages and restores the registers: level 0, nudging off, tolerance 1,
// clockwise winding. The receiver cannot stall: the divider pipeline never
// holds, and busy alone throttles the sender.
module marching_squares_cell_edges (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [msce_pkg::ADDR_W-1:0]        paddr,
  input  logic [msce_pkg::DATA_W-1:0]        pwdata,
  output logic [msce_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic [msce_pkg::IDX_W-1:0]         cell_first,
  input  logic [msce_pkg::IDX_W-1:0]         cell_second,
  input  logic signed [msce_pkg::SMP_W-1:0]  corner_00,
  input  logic signed [msce_pkg::SMP_W-1:0]  corner_10,
  input  logic signed [msce_pkg::SMP_W-1:0]  corner_01,
  input  logic signed [msce_pkg::SMP_W-1:0]  corner_11,
  output logic                               strobe,
  output logic [msce_pkg::OUT_W-1:0]         start_first,
  output logic [msce_pkg::OUT_W-1:0]         start_second,
  output logic [msce_pkg::OUT_W-1:0]         end_first,
  output logic [msce_pkg::OUT_W-1:0]         end_second,
  output logic                               last_segment
);
  import msce_pkg::*;

  // Configuration registers.
  logic signed [SMP_W-1:0] iso_level;
  logic                    nudge_enable;
  logic [TOL_W-1:0]        nudge_tolerance;
  logic                    reverse_winding;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level       <= '0;
      nudge_enable    <= 1'b0;
      nudge_tolerance <= TOL_W'(1);
      reverse_winding <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ISO_LEVEL:       iso_level       <= pwdata[SMP_W-1:0];
        REG_NUDGE_ENABLE:    nudge_enable    <= pwdata[0];
        REG_NUDGE_TOLERANCE: nudge_tolerance <= pwdata[TOL_W-1:0];
        REG_REVERSE_WINDING: reverse_winding <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ISO_LEVEL:       prdata = DATA_W'(signed'(iso_level));
      REG_NUDGE_ENABLE:    prdata = DATA_W'(nudge_enable);
      REG_NUDGE_TOLERANCE: prdata = DATA_W'(nudge_tolerance);
      REG_REVERSE_WINDING: prdata = DATA_W'(reverse_winding);
      default:             prdata = '0;
    endcase
  end

  // Pipeline registers.
  logic                    s1_valid, s2_valid, s3_valid, iss_valid;
  logic signed [NUM_W-1:0] s1_f [4];
  logic signed [NUM_W-1:0] s2_f [4];
  logic signed [NUM_W-1:0] s3_f [4];
  logic signed [NUM_W-1:0] iss_f [4];
  logic [IDX_W-1:0]        s1_i, s1_j, s2_i, s2_j, s3_i, s3_j, iss_i, iss_j;
  logic signed [PRD_W-1:0] s2_pbd, s2_pac;
  logic [3:0][15:0]        s3_seg, iss_seg;
  logic [2:0]              s3_cnt, iss_cnt;
  logic [1:0]              iss_idx;

  // Flow control: the issuer frees up on its last segment; each stage moves
  // when the one after it is open.
  logic iss_last, iss_free, iss_load, s3_go, s3_open, s2_go, s2_open;
  logic s1_go, s1_open, accept;

  assign iss_last = iss_valid && ({1'b0, iss_idx} == iss_cnt - 3'd1);
  assign iss_free = !iss_valid || iss_last;
  assign s3_go    = s3_valid && (s3_cnt == 3'd0 || iss_free);
  assign iss_load = s3_valid && s3_cnt != 3'd0 && iss_free;
  assign s3_open  = !s3_valid || s3_go;
  assign s2_go    = s2_valid && s3_open;
  assign s2_open  = !s2_valid || s2_go;
  assign s1_go    = s1_valid && s2_open;
  assign s1_open  = !s1_valid || s1_go;
  assign busy     = !s1_open;
  assign accept   = start && !busy;

  // Stage 1: shift by the level and nudge away from zero.
  logic signed [NUM_W-1:0] lvl [4];
  logic signed [NUM_W-1:0] tol;
  logic signed [SMP_W-1:0] raw [4];

  always_comb begin
    raw[0] = corner_00;
    raw[1] = corner_10;
    raw[2] = corner_01;
    raw[3] = corner_11;
    tol = NUM_W'(nudge_tolerance);
    for (int k = 0; k < 4; k++) begin
      lvl[k] = NUM_W'(raw[k]) - NUM_W'(iso_level);
      if (nudge_enable) begin
        if (lvl[k] < 0) begin
          if (lvl[k] > -tol) lvl[k] = -tol;
        end else if (lvl[k] < tol) begin
          lvl[k] = tol;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_go);
    end
    if (accept) begin
      s1_f <= lvl;
      s1_i <= cell_first;
      s1_j <= cell_second;
    end
  end

  // Stage 2: saddle determinant products (sign does not depend on the flip).
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_go || (s2_valid && !s2_go);
    end
    if (s1_go) begin
      s2_f   <= s1_f;
      s2_i   <= s1_i;
      s2_j   <= s1_j;
      s2_pbd <= s1_f[1] * s1_f[2];
      s2_pac <= s1_f[0] * s1_f[3];
    end
  end

  // Stage 3: case tree over corner signs.
  function automatic logic signed [1:0] sgn2(input logic signed [NUM_W-1:0] v);
    sgn2 = (v > 0) ? SG_POS : ((v < 0) ? SG_NEG : SG_ZERO);
  endfunction

  logic signed [1:0] sb, sc, sd;
  logic              det_pos;
  logic [3:0][15:0]  tree_seg;
  logic [2:0]        tree_cnt;

  always_comb begin
    det_pos  = (DET_W'(s2_pbd) - DET_W'(s2_pac)) > 0;
    tree_seg = '0;
    tree_cnt = 3'd0;
    sb = sgn2(s2_f[1]);
    sc = sgn2(s2_f[3]);
    sd = sgn2(s2_f[2]);
    if (s2_f[0] != 0) begin
      if (s2_f[0] < 0) begin
        sb = -sb;
        sc = -sc;
        sd = -sd;
      end
      if (sb == SG_POS) begin
        if (sc == SG_POS) begin
          if (sd != SG_POS) begin tree_cnt = 3'd1; tree_seg[0] = 16'h2320; end
        end else if (sc == SG_NEG) begin
          tree_cnt = 3'd1;
          if (sd == SG_POS)      tree_seg[0] = 16'h1332;
          else if (sd == SG_NEG) tree_seg[0] = 16'h2013;
          else                   tree_seg[0] = 16'h2213;
        end else begin
          if (sd == SG_NEG) begin
            tree_cnt = 3'd1; tree_seg[0] = 16'h3302;
          end else if (sd == SG_ZERO) begin
            tree_cnt = 3'd1; tree_seg[0] = 16'h3322;
          end
        end
      end else if (sb == SG_NEG) begin
        if (sc == SG_POS) begin
          if (sd == SG_NEG) begin
            tree_cnt = 3'd2;
            if (det_pos) begin
              tree_seg[0] = 16'h3231; tree_seg[1] = 16'h0102;
            end else begin
              tree_seg[0] = 16'h3202; tree_seg[1] = 16'h0131;
            end
          end else begin
            tree_cnt = 3'd1; tree_seg[0] = 16'h0131;
          end
        end else if (sc == SG_NEG) begin
          tree_cnt = 3'd1;
          if (sd == SG_POS)      tree_seg[0] = 16'h0132;
          else if (sd == SG_NEG) tree_seg[0] = 16'h2001;
          else                   tree_seg[0] = 16'h2201;
        end else begin
          if (sd == SG_POS) begin
            tree_cnt = 3'd1; tree_seg[0] = 16'h3301;
          end else if (sd == SG_NEG) begin
            tree_cnt = 3'd1; tree_seg[0] = 16'h2001;
          end else begin
            tree_cnt = 3'd3;
            tree_seg[0] = 16'h3323; tree_seg[1] = 16'h2322; tree_seg[2] = 16'h2301;
          end
        end
      end else begin
        if (sc == SG_POS) begin
          if (sd == SG_NEG) begin tree_cnt = 3'd1; tree_seg[0] = 16'h2320; end
        end else if (sc == SG_NEG) begin
          tree_cnt = 3'd1;
          if (sd == SG_POS)      tree_seg[0] = 16'h1123;
          else if (sd == SG_NEG) tree_seg[0] = 16'h1102;
          else                   tree_seg[0] = 16'h1122;
        end else begin
          if (sd == SG_POS) begin
            tree_cnt = 3'd1; tree_seg[0] = 16'h1133;
          end else if (sd == SG_NEG) begin
            tree_cnt = 3'd3;
            tree_seg[0] = 16'h1113; tree_seg[1] = 16'h1333; tree_seg[2] = 16'h1302;
          end else begin
            tree_cnt = 3'd2; tree_seg[0] = 16'h2200; tree_seg[1] = 16'h0011;
          end
        end
      end
    end else if (s2_f[1] != 0) begin
      if (s2_f[1] < 0) begin
        sc = -sc;
        sd = -sd;
      end
      if (sc == SG_POS) begin
        if (sd == SG_NEG) begin
          tree_cnt = 3'd1; tree_seg[0] = 16'h0023;
        end else if (sd == SG_ZERO) begin
          tree_cnt = 3'd1; tree_seg[0] = 16'h2200;
        end
      end else if (sc == SG_NEG) begin
        if (sd == SG_POS) begin
          tree_cnt = 3'd1; tree_seg[0] = 16'h1332;
        end else if (sd == SG_NEG) begin
          tree_cnt = 3'd1; tree_seg[0] = 16'h0013;
        end else begin
          tree_cnt = 3'd3;
          tree_seg[0] = 16'h0002; tree_seg[1] = 16'h0222; tree_seg[2] = 16'h0213;
        end
      end else begin
        if (sd == SG_NEG) begin
          tree_cnt = 3'd1; tree_seg[0] = 16'h0033;
        end else if (sd == SG_ZERO) begin
          tree_cnt = 3'd2; tree_seg[0] = 16'h3322; tree_seg[1] = 16'h2200;
        end
      end
    end else if (s2_f[3] != 0) begin
      if (s2_f[3] < 0) sd = -sd;
      if (sd == SG_POS) begin
        tree_cnt = 3'd1; tree_seg[0] = 16'h0011;
      end else if (sd == SG_NEG) begin
        tree_cnt = 3'd3;
        tree_seg[0] = 16'h0001; tree_seg[1] = 16'h0111; tree_seg[2] = 16'h0123;
      end else begin
        tree_cnt = 3'd2; tree_seg[0] = 16'h1133; tree_seg[1] = 16'h3322;
      end
    end else if (s2_f[2] != 0) begin
      tree_cnt = 3'd2; tree_seg[0] = 16'h0011; tree_seg[1] = 16'h1133;
    end else begin
      tree_cnt = 3'd4;
      tree_seg[0] = 16'h0011; tree_seg[1] = 16'h1133;
      tree_seg[2] = 16'h3322; tree_seg[3] = 16'h2200;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_go || (s3_valid && !s3_go);
    end
    if (s2_go) begin
      s3_f   <= s2_f;
      s3_i   <= s2_i;
      s3_j   <= s2_j;
      s3_seg <= tree_seg;
      s3_cnt <= tree_cnt;
    end
  end

  // Issuer: hand one segment per cycle to the edge units; drop empty cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
      iss_idx   <= 2'd0;
    end else if (iss_load) begin
      iss_valid <= 1'b1;
      iss_idx   <= 2'd0;
    end else if (iss_valid) begin
      iss_valid <= !iss_last;
      iss_idx   <= iss_idx + 2'd1;
    end
    if (iss_load) begin
      iss_f   <= s3_f;
      iss_i   <= s3_i;
      iss_j   <= s3_j;
      iss_seg <= s3_seg;
      iss_cnt <= s3_cnt;
    end
  end

  // Pick endpoint corners; reverse winding swaps start and end here.
  logic [15:0] cur;
  logic [1:0]  sa_c, sb_c, ea_c, eb_c;

  always_comb begin
    cur = iss_seg[iss_idx];
    if (reverse_winding) begin
      sa_c = cur[5:4];   sb_c = cur[1:0];
      ea_c = cur[13:12]; eb_c = cur[9:8];
    end else begin
      sa_c = cur[13:12]; sb_c = cur[9:8];
      ea_c = cur[5:4];   eb_c = cur[1:0];
    end
  end

  msce_edge u_start (
    .clk      (clk),
    .v_a      (iss_f[sa_c]),
    .v_b      (iss_f[sb_c]),
    .corner_a (sa_c),
    .corner_b (sb_c),
    .cell_i   (iss_i),
    .cell_j   (iss_j),
    .x        (start_first),
    .y        (start_second)
  );

  msce_edge u_end (
    .clk      (clk),
    .v_a      (iss_f[ea_c]),
    .v_b      (iss_f[eb_c]),
    .corner_a (ea_c),
    .corner_b (eb_c),
    .cell_i   (iss_i),
    .cell_j   (iss_j),
    .x        (end_first),
    .y        (end_second)
  );

  // Strobe and last-segment flag travel alongside the edge units.
  logic [EDGE_LAT-1:0] vpipe, lpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[EDGE_LAT-2:0], iss_valid};
    end
    lpipe <= {lpipe[EDGE_LAT-2:0], iss_last};
  end

  assign strobe       = vpipe[EDGE_LAT-1];
  assign last_segment = vpipe[EDGE_LAT-1] && lpipe[EDGE_LAT-1];

endmodule

>>> rtl/msce_edge.sv
// Pipelined edge-point unit: restoring division one bit per stage, then placement.
module msce_edge (
  input  logic                              clk,
  input  logic signed [msce_pkg::NUM_W-1:0] v_a,
  input  logic signed [msce_pkg::NUM_W-1:0] v_b,
  input  logic [1:0]                        corner_a,
  input  logic [1:0]                        corner_b,
  input  logic [msce_pkg::IDX_W-1:0]        cell_i,
  input  logic [msce_pkg::IDX_W-1:0]        cell_j,
  output logic [msce_pkg::OUT_W-1:0]        x,
  output logic [msce_pkg::OUT_W-1:0]        y
);
  import msce_pkg::*;

  localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << FRAC_BITS;

  msce_div_t st [0:QUO_W];
  msce_div_t st0;
  logic signed [DEN_W-1:0] diff;

  always_comb begin
    diff = DEN_W'(v_b) - DEN_W'(v_a);
    st0 = '0;
    st0.rem = REM_W'(v_a < 0 ? -v_a : v_a);
    st0.den = diff < 0 ? DEN_W'(-diff) : DEN_W'(diff);
    if (diff == 0) begin
      st0.mode = MODE_HALF;
    end else if ((v_a < 0 && diff > 0) || (v_a > 0 && diff < 0)) begin
      st0.mode = MODE_DIV;
    end else begin
      st0.mode = MODE_ZERO;
    end
    st0.ci = cell_i;
    st0.cj = cell_j;
    st0.ca = corner_a;
    st0.cb = corner_b;
  end

  always_ff @(posedge clk) begin
    st[0] <= st0;
  end

  genvar t;
  generate
    for (t = 0; t < QUO_W; t++) begin : g_step
      msce_div_t nxt;
      logic [REM_W-1:0] red;
      logic qbit;
      always_comb begin
        nxt  = st[t];
        qbit = st[t].rem >= REM_W'(st[t].den);
        red  = qbit ? st[t].rem - REM_W'(st[t].den) : st[t].rem;
        nxt.rem = {red[REM_W-2:0], 1'b0};
        nxt.quo = {st[t].quo[QUO_W-2:0], qbit};
        if (t == 0) begin
          nxt.ovf = st[t].rem >= {st[t].den, 1'b0};
        end
      end
      always_ff @(posedge clk) begin
        st[t+1] <= nxt;
      end
    end
  endgenerate

  msce_div_t fin;
  logic [QUO_W-1:0] off;
  logic [OUT_W-1:0] base_x, base_y, off_w, x_next, y_next;

  always_comb begin
    fin = st[QUO_W];
    case (fin.mode)
      MODE_ZERO: off = '0;
      MODE_HALF: off = ONE >> 1;
      MODE_DIV:  off = (fin.ovf || fin.quo > ONE) ? ONE : fin.quo;
      default:   off = '0;
    endcase
    off_w  = OUT_W'(off);
    base_x = (OUT_W'(fin.ci) + OUT_W'(fin.ca[0])) << FRAC_BITS;
    base_y = (OUT_W'(fin.cj) + OUT_W'(fin.ca[1])) << FRAC_BITS;
    x_next = base_x;
    y_next = base_y;
    if (fin.cb[0] && !fin.ca[0]) x_next = base_x + off_w;
    if (fin.ca[0] && !fin.cb[0]) x_next = base_x - off_w;
    if (fin.cb[1] && !fin.ca[1]) y_next = base_y + off_w;
    if (fin.ca[1] && !fin.cb[1]) y_next = base_y - off_w;
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
  end

endmodule

>>> rtl/msce_checker.sv
// Port-level checks for the marching-squares cell edge block, bound to the top.
module msce_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [msce_pkg::ADDR_W-1:0] paddr,
  input logic [msce_pkg::DATA_W-1:0] pwdata,
  input logic [msce_pkg::DATA_W-1:0] prdata,
  input logic                        pready,
  input logic                        busy,
  input logic                        strobe
);
  import msce_pkg::*;

  // Reset empties every stage.
  a_reset_clears: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("pipeline not empty after reset");

  // Tolerance reads back as one right after reset.
  a_tol_reset: assert property (@(posedge clk)
    rst |=> (paddr[3:2] != REG_NUDGE_TOLERANCE || prdata == DATA_W'(1)))
    else $error("tolerance reset value wrong");

  // A level write reads back sign-extended.
  a_iso_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[3:2] == REG_ISO_LEVEL)
    |=> (paddr[3:2] != REG_ISO_LEVEL ||
         prdata == DATA_W'(signed'($past(pwdata[SMP_W-1:0])))))
    else $error("iso level readback mismatch");

  // A tolerance write reads back masked to its width.
  a_tol_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[3:2] == REG_NUDGE_TOLERANCE)
    |=> (paddr[3:2] != REG_NUDGE_TOLERANCE ||
         prdata == DATA_W'($past(pwdata[TOL_W-1:0]))))
    else $error("tolerance readback mismatch");

endmodule

bind marching_squares_cell_edges msce_checker u_msce_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the marching-squares cell edge block.
`timescale 1ns / 100ps

module tb_top;
  import msce_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [IDX_W-1:0] cell_first = '0, cell_second = '0;
  logic signed [SMP_W-1:0] corner_00 = '0, corner_10 = '0, corner_01 = '0, corner_11 = '0;
  logic strobe;
  logic [OUT_W-1:0] start_first, start_second, end_first, end_second;
  logic last_segment;

  marching_squares_cell_edges u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .cell_first(cell_first), .cell_second(cell_second),
    .corner_00(corner_00), .corner_10(corner_10), .corner_01(corner_01),
    .corner_11(corner_11), .strobe(strobe), .start_first(start_first),
    .start_second(start_second), .end_first(end_first), .end_second(end_second),
    .last_segment(last_segment)
  );

  typedef struct {
    logic [OUT_W-1:0] sf, ss, ef, es;
    logic             last;
  } segment_t;

  // One directed cell; typed rows carry their segment list in place of the predictor.
  typedef struct {
    logic [IDX_W-1:0]        ci, cj;
    logic signed [SMP_W-1:0] c00, c10, c01, c11;
    bit                      typed;
    int                      typed_n;
    logic [OUT_W-1:0]        tv [16];
  } cell_row_t;

  segment_t pending_segs[$];
  int       errors;
  int       cells_sent;
  int       segs_seen;

  // Shadow of the configuration registers.
  longint   lvl_shadow;
  bit       nudge_shadow;
  longint   tol_shadow;
  bit       rev_shadow;

  // Level-shifted corner values of the cell being predicted, by corner code.
  longint   shifted [4];

  localparam longint ONE = 64'sd1 <<< FRAC_BITS;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 400000);
    $display("timeout waiting for segments");
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Append one expected segment at the tail of the pending queue.
  function automatic void queue_seg(input segment_t sg);
    pending_segs.insert(pending_segs.size(), sg);
  endfunction

  // Interpolate the crossing on the edge from corner pa to corner pb.
  function automatic void edge_pt(input longint ci, input longint cj, input logic [3:0] pa,
                                  input logic [3:0] pb, output logic [OUT_W-1:0] x,
                                  output logic [OUT_W-1:0] y);
    longint v1, v2, delta, off, ax, ay, bx, by, tx, ty;
    v1 = shifted[pa[1:0]];
    v2 = shifted[pb[1:0]];
    delta = v2 - v1;
    ax = longint'(pa[0]); ay = longint'(pa[1]); bx = longint'(pb[0]); by = longint'(pb[1]);
    if (delta == 0) off = ONE >>> 1;
    else off = (-v1 * ONE) / delta;
    if (off < 0) off = 0;
    if (off > ONE) off = ONE;
    tx = (ci + ax) * ONE + off * (bx - ax);
    ty = (cj + ay) * ONE + off * (by - ay);
    x = tx[OUT_W-1:0];
    y = ty[OUT_W-1:0];
  endfunction

  // Shift, nudge, walk the case tree and queue the segments this cell yields.
  function automatic void predict_segments(input logic [IDX_W-1:0] ci, input logic [IDX_W-1:0] cj,
                                           input logic signed [SMP_W-1:0] s00,
                                           input logic signed [SMP_W-1:0] s10,
                                           input logic signed [SMP_W-1:0] s01,
                                           input logic signed [SMP_W-1:0] s11);
    longint a, b, c, d;
    logic [63:0] codes;
    int n;
    segment_t sg;
    logic [15:0] cd;
    logic [OUT_W-1:0] sx, sy, ex, ey;
    shifted[0] = longint'(s00); shifted[1] = longint'(s10);
    shifted[2] = longint'(s01); shifted[3] = longint'(s11);
    for (int k = 0; k < 4; k++) begin
      shifted[k] -= lvl_shadow;
      if (nudge_shadow) begin
        if (shifted[k] < 0) begin
          if (shifted[k] > -tol_shadow) shifted[k] = -tol_shadow;
        end else if (shifted[k] < tol_shadow) begin
          shifted[k] = tol_shadow;
        end
      end
    end
    a = shifted[0]; b = shifted[1]; c = shifted[3]; d = shifted[2];
    codes = '0;
    n = 0;
    if (a != 0) begin
      // Flip so corner 00 is positive.
      if (a < 0) begin
        a = -a; b = -b; c = -c; d = -d;
      end
      if (b > 0) begin
        if (c > 0) begin
          if (d <= 0) begin codes = 64'h2320_0000_0000_0000; n = 1; end
        end else if (c < 0) begin
          if (d > 0) begin codes = 64'h1332_0000_0000_0000; n = 1; end
          else if (d < 0) begin codes = 64'h2013_0000_0000_0000; n = 1; end
          else begin codes = 64'h2213_0000_0000_0000; n = 1; end
        end else begin
          if (d < 0) begin codes = 64'h3302_0000_0000_0000; n = 1; end
          else if (d == 0) begin codes = 64'h3322_0000_0000_0000; n = 1; end
        end
      end else if (b < 0) begin
        if (c > 0) begin
          if (d < 0) begin
            // Saddle: the determinant picks which diagonal pair connects.
            if (b * d - a * c > 0) begin codes = 64'h3231_0102_0000_0000; n = 2; end
            else begin codes = 64'h3202_0131_0000_0000; n = 2; end
          end else begin codes = 64'h0131_0000_0000_0000; n = 1; end
        end else if (c < 0) begin
          if (d > 0) begin codes = 64'h0132_0000_0000_0000; n = 1; end
          else if (d < 0) begin codes = 64'h2001_0000_0000_0000; n = 1; end
          else begin codes = 64'h2201_0000_0000_0000; n = 1; end
        end else begin
          if (d > 0) begin codes = 64'h3301_0000_0000_0000; n = 1; end
          else if (d < 0) begin codes = 64'h2001_0000_0000_0000; n = 1; end
          else begin codes = 64'h3323_2322_2301_0000; n = 3; end
        end
      end else begin
        if (c > 0) begin
          if (d < 0) begin codes = 64'h2320_0000_0000_0000; n = 1; end
        end else if (c < 0) begin
          if (d > 0) begin codes = 64'h1123_0000_0000_0000; n = 1; end
          else if (d < 0) begin codes = 64'h1102_0000_0000_0000; n = 1; end
          else begin codes = 64'h1122_0000_0000_0000; n = 1; end
        end else begin
          if (d > 0) begin codes = 64'h1133_0000_0000_0000; n = 1; end
          else if (d < 0) begin codes = 64'h1113_1333_1302_0000; n = 3; end
          else begin codes = 64'h2200_0011_0000_0000; n = 2; end
        end
      end
    end else if (b != 0) begin
      if (b < 0) begin
        c = -c; d = -d;
      end
      if (c > 0) begin
        if (d < 0) begin codes = 64'h0023_0000_0000_0000; n = 1; end
        else if (d == 0) begin codes = 64'h2200_0000_0000_0000; n = 1; end
      end else if (c < 0) begin
        if (d > 0) begin codes = 64'h1332_0000_0000_0000; n = 1; end
        else if (d < 0) begin codes = 64'h0013_0000_0000_0000; n = 1; end
        else begin codes = 64'h0002_0222_0213_0000; n = 3; end
      end else begin
        if (d < 0) begin codes = 64'h0033_0000_0000_0000; n = 1; end
        else if (d == 0) begin codes = 64'h3322_2200_0000_0000; n = 2; end
      end
    end else if (c != 0) begin
      if (c < 0) d = -d;
      if (d > 0) begin codes = 64'h0011_0000_0000_0000; n = 1; end
      else if (d < 0) begin codes = 64'h0001_0111_0123_0000; n = 3; end
      else begin codes = 64'h1133_3322_0000_0000; n = 2; end
    end else if (d != 0) begin
      codes = 64'h0011_1133_0000_0000; n = 2;
    end else begin
      codes = 64'h0011_1133_3322_2200; n = 4;
    end
    for (int k = 0; k < n; k++) begin
      cd = codes[63 - 16 * k -: 16];
      edge_pt(ci, cj, cd[15:12], cd[11:8], sx, sy);
      edge_pt(ci, cj, cd[7:4], cd[3:0], ex, ey);
      if (rev_shadow) begin
        sg.sf = ex; sg.ss = ey; sg.ef = sx; sg.es = sy;
      end else begin
        sg.sf = sx; sg.ss = sy; sg.ef = ex; sg.es = ey;
      end
      sg.last = (k == n - 1);
      queue_seg(sg);
    end
  endfunction

  // Two-phase APB write; the register takes the value at the access edge.
  task automatic apb_write(input logic [1:0] reg_idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (reg_idx)
      REG_ISO_LEVEL:       lvl_shadow = longint'($signed(val[15:0]));
      REG_NUDGE_ENABLE:    nudge_shadow = val[0];
      REG_NUDGE_TOLERANCE: tol_shadow = longint'(val[TOL_W-1:0]);
      REG_REVERSE_WINDING: rev_shadow = val[0];
      default: ;
    endcase
  endtask

  // Drain all segments, let cells with no segment clear, then reprogram.
  task automatic set_config(input logic [15:0] lvl, input bit nen, input logic [14:0] tol,
                            input bit rev);
    wait (pending_segs.size() == 0);
    repeat (40) @(posedge clk);
    apb_write(REG_ISO_LEVEL, {16'h0, lvl});
    apb_write(REG_NUDGE_ENABLE, {31'h0, nen});
    apb_write(REG_NUDGE_TOLERANCE, {17'h0, tol});
    apb_write(REG_REVERSE_WINDING, {31'h0, rev});
  endtask

  // Keep start low through random idle cycles, present a cell, wait for it to be taken.
  task automatic send_cell(input int idle_pct, input cell_row_t row);
    segment_t sg;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cell_first <= row.ci; cell_second <= row.cj;
    corner_00 <= row.c00; corner_10 <= row.c10;
    corner_01 <= row.c01; corner_11 <= row.c11;
    do @(posedge clk); while (busy);
    cells_sent++;
    if (row.typed) begin
      for (int k = 0; k < row.typed_n; k++) begin
        sg.sf = row.tv[4*k]; sg.ss = row.tv[4*k+1];
        sg.ef = row.tv[4*k+2]; sg.es = row.tv[4*k+3];
        sg.last = (k == row.typed_n - 1);
        queue_seg(sg);
      end
    end else begin
      predict_segments(row.ci, row.cj, row.c00, row.c10, row.c01, row.c11);
    end
  endtask

  // Sample near the level so zero corners and sign changes come often.
  function automatic logic signed [SMP_W-1:0] pick_sample();
    int r;
    logic signed [SMP_W-1:0] v;
    r = $urandom_range(99);
    if (r < 40) v = SMP_W'($urandom);
    else if (r < 80) v = SMP_W'(lvl_shadow + longint'($urandom_range(8)) - 4);
    else v = SMP_W'(lvl_shadow);
    return v;
  endfunction

  function automatic cell_row_t random_cell();
    cell_row_t row;
    row.typed = 1'b0;
    row.typed_n = 0;
    row.ci = ($urandom_range(19) == 0) ? 10'h3FF : 10'($urandom);
    row.cj = ($urandom_range(19) == 0) ? 10'h3FF : 10'($urandom);
    row.c00 = pick_sample(); row.c10 = pick_sample();
    row.c01 = pick_sample(); row.c11 = pick_sample();
    return row;
  endfunction

  // Check each strobed segment against the oldest pending one.
  always @(posedge clk) begin
    segment_t want;
    if (!rst && strobe) begin
      segs_seen++;
      if (pending_segs.size() == 0) begin
        report_mismatch("segment with none pending");
      end else begin
        want = pending_segs.pop_front();
        if (start_first !== want.sf || start_second !== want.ss || end_first !== want.ef ||
            end_second !== want.es || last_segment !== want.last)
          report_mismatch($sformatf("got %h %h %h %h %b want %h %h %h %h %b",
            start_first, start_second, end_first, end_second, last_segment,
            want.sf, want.ss, want.ef, want.es, want.last));
      end
    end
  end

  cell_row_t directed [$];

  // Append one directed row at the tail of the table.
  function automatic void add_row(input cell_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    cell_row_t row;
    int phase_pct;
    errors = 0; cells_sent = 0; segs_seen = 0;
    lvl_shadow = 0; nudge_shadow = 0; tol_shadow = 1; rev_shadow = 0;

    // All corners at the level: the whole cell boundary, four segments.
    row = '{ci: 0, cj: 0, c00: 0, c10: 0, c01: 0, c11: 0, typed: 1, typed_n: 4, tv: '{default: 0}};
    row.tv = '{0, 0, 65536, 0,  65536, 0, 65536, 65536,
               65536, 65536, 0, 65536,  0, 65536, 0, 0};
    add_row(row);
    // All corners above the level: nothing.
    row = '{ci: 1023, cj: 1023, c00: 32767, c10: 32767, c01: 32767, c11: 32767,
            typed: 1, typed_n: 0, tv: '{default: 0}};
    add_row(row);
    row.typed = 0;
    // Sign flip of an all-negative cell, single-corner cases, saddles both ways,
    // zero corners in each position, and full-scale extremes at the border.
    row.ci = 1023; row.cj = 0;
    row.c00 = -32768; row.c10 = -32768; row.c01 = -32768; row.c11 = -32768; add_row(row);
    row.c00 = 100;  row.c10 = -100; row.c01 = -100; row.c11 = -100; add_row(row);
    row.c00 = 100;  row.c10 = -50;  row.c01 = -50;  row.c11 = 200;  add_row(row);
    row.c00 = 30;   row.c10 = -100; row.c01 = -100; row.c11 = 30;   add_row(row);
    row.c00 = 100;  row.c10 = -100; row.c01 = -100; row.c11 = 100;  add_row(row);
    row.c00 = 0;    row.c10 = 100;  row.c01 = -100; row.c11 = 0;    add_row(row);
    row.c00 = 0;    row.c10 = 0;    row.c01 = 0;    row.c11 = 5;    add_row(row);
    row.c00 = 0;    row.c10 = 0;    row.c01 = 5;    row.c11 = 0;    add_row(row);
    row.c00 = 0;    row.c10 = 5;    row.c01 = 0;    row.c11 = -5;   add_row(row);
    row.c00 = 5;    row.c10 = 0;    row.c01 = 0;    row.c11 = 0;    add_row(row);
    row.c00 = 5;    row.c10 = -5;   row.c01 = 0;    row.c11 = 0;    add_row(row);
    row.c00 = -5;   row.c10 = 0;    row.c01 = 5;    row.c11 = 0;    add_row(row);
    row.c00 = 0;    row.c10 = -7;   row.c01 = 0;    row.c11 = 0;    add_row(row);
    row.c00 = 0;    row.c10 = 0;    row.c01 = -3;   row.c11 = 4;    add_row(row);
    row.ci = 1023; row.cj = 1023;
    row.c00 = 32767;  row.c10 = -32768; row.c01 = -32768; row.c11 = 32767;  add_row(row);
    row.c00 = -32768; row.c10 = 32767;  row.c01 = 32767;  row.c11 = -32768; add_row(row);
    row.ci = 0; row.cj = 1023;
    row.c00 = 1;      row.c10 = -32768; row.c01 = 32767;  row.c11 = -1;     add_row(row);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_cell(21, directed[k]);
    start <= 1'b0;

    // Six settings, extremes first; sender idling 21%, then 86%, then none.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(16'h0000, 1'b0, 15'd1, 1'b0);
        1: set_config(16'h8000, 1'b1, 15'h7FFF, 1'b1);
        2: set_config(16'h7FFF, 1'b1, 15'd0, 1'b0);
        3: set_config(16'($urandom), 1'b0, 15'($urandom), 1'b1);
        4: set_config(16'($urandom), 1'b1, 15'($urandom_range(6)), 1'b1);
        default: set_config(16'($urandom), 1'($urandom), 15'($urandom), 1'($urandom));
      endcase
      phase_pct = (ph < 2) ? 21 : (ph < 4) ? 86 : 0;
      for (int k = 0; k < 50; k++) send_cell(phase_pct, random_cell());
      start <= 1'b0;
    end

    wait (pending_segs.size() == 0);
    repeat (40) @(posedge clk);
    $display("cells sent: %0d, segments checked: %0d, mismatches: %0d",
             cells_sent, segs_seen, errors);
    $display("covered level, nudge and winding extremes, saddles and zero-corner cases");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/msce_pkg.sv
rtl/msce_edge.sv
rtl/marching_squares_cell_edges.sv
rtl/msce_checker.sv
dv/tb_top.sv
